### hw/rtl/asf_pkg.sv
// asf_pkg: shared types and constants of the arrive steering force core
// holds the configuration struct, register codes and pipeline payload structs
// no dependencies
`default_nettype none

package asf_pkg;

    // configuration port geometry
    localparam int ASF_ADDR_W = 4;
    localparam int ASF_DATA_W = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] ASF_REG_MAX_SPEED = 2'd0;
    localparam logic [1:0] ASF_REG_MAX_FORCE = 2'd1;
    localparam logic [1:0] ASF_REG_WEIGHT    = 2'd2;
    localparam logic [1:0] ASF_REG_DECEL     = 2'd3;

    // deceleration codes
    localparam logic [1:0] ASF_DECEL_NONE   = 2'd0;
    localparam logic [1:0] ASF_DECEL_FAST   = 2'd1;
    localparam logic [1:0] ASF_DECEL_NORMAL = 2'd2;
    localparam logic [1:0] ASF_DECEL_SLOW   = 2'd3;

    // reset values
    localparam logic [30:0] ASF_MAX_SPEED_RST = 31'd327680;
    localparam logic [30:0] ASF_MAX_FORCE_RST = 31'd327680;
    localparam logic [15:0] ASF_WEIGHT_RST    = 16'd256;
    localparam logic [1:0]  ASF_DECEL_RST     = ASF_DECEL_FAST;

    typedef struct packed {
        logic [30:0] max_speed;
        logic [30:0] max_force;
        logic [15:0] gain;
        logic [1:0]  decel_rate;
    } asf_cfg_t;

    // offset magnitudes, signs and velocity carried around the first root
    typedef struct packed {
        logic [2:0][32:0] dmag;
        logic [2:0]       dneg;
        logic [2:0][31:0] vel;
    } asf_vec_t;

    // payload around the speed divider
    typedef struct packed {
        asf_vec_t    vec;
        logic [32:0] dlen;
    } asf_spd_pl_t;

    // per lane payload around the desired velocity divider
    typedef struct packed {
        logic        dnz;
        logic        dneg;
        logic [31:0] vel;
    } asf_des_pl_t;

    // payload around the force length root
    typedef struct packed {
        logic [2:0][55:0] wmag;
        logic [2:0]       wneg;
    } asf_w_pl_t;

    // per lane payload around the force clip divider
    typedef struct packed {
        logic        zero;
        logic        le;
        logic        wneg;
        logic [30:0] wlow;
    } asf_f_pl_t;

endpackage

`default_nettype wire

### hw/rtl/asf_sqrt_pipe.sv
// asf_sqrt_pipe: pipelined integer square root, one root bit per stage
// carries a payload vector beside the radicand; no package dependency
`default_nettype none

module asf_sqrt_pipe #(
    parameter int XW = 66,
    parameter int PW = 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [XW-1:0]       in_x,
    input  wire logic [PW-1:0]       in_pl,
    output logic                     out_valid,
    output logic [XW/2-1:0]          out_root,
    output logic [PW-1:0]            out_pl
);

    localparam int RW  = XW / 2;
    localparam int RMW = RW + 2;

    logic [RW-1:0]  vld_reg;
    logic [RMW-1:0] rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    logic [XW-1:0]  x_reg    [RW];
    logic [PW-1:0]  pl_reg   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RMW-1:0] rem_src;
        logic [RW-1:0]  root_src;
        logic [XW-1:0]  x_src;
        logic [PW-1:0]  pl_src;
        logic           vld_src;
        logic [RMW+1:0] rem_sh;
        logic [RMW+1:0] trial;
        logic           ge;
        logic [RMW+1:0] rem_diff;
        logic [RMW-1:0] rem_next;
        logic [RW-1:0]  root_next;
        logic [XW-1:0]  x_next;

        // stage source: module inputs or previous stage
        if (k == 0) begin : g_first
            assign rem_src  = '0;
            assign root_src = '0;
            assign x_src    = in_x;
            assign pl_src   = in_pl;
            assign vld_src  = in_valid;
        end else begin : g_next
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign x_src    = x_reg[k-1];
            assign pl_src   = pl_reg[k-1];
            assign vld_src  = vld_reg[k-1];
        end

        // bring down two radicand bits and try a one bit
        always_comb
        begin
            rem_sh    = {rem_src, x_src[XW-1:XW-2]};
            trial     = {2'b00, root_src, 2'b01};
            ge        = (rem_sh >= trial);
            rem_diff  = ge ? (rem_sh - trial) : rem_sh;
            rem_next  = rem_diff[RMW-1:0];
            root_next = {root_src[RW-2:0], ge};
            x_next    = {x_src[XW-3:0], 2'b00};
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_src;
            end
        end

        // stage data
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                x_reg[k]    <= x_next;
                pl_reg[k]   <= pl_src;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_pl    = pl_reg[RW-1];

endmodule

`default_nettype wire

### hw/rtl/asf_div_pipe.sv
// asf_div_pipe: pipelined restoring divider, one quotient bit per stage
// needs num >> QW below den; carries a payload vector; no package dependency
`default_nettype none

module asf_div_pipe #(
    parameter int NW = 64,
    parameter int DW = 33,
    parameter int QW = 63,
    parameter int PW = 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [NW-1:0]  in_num,
    input  wire logic [DW-1:0]  in_den,
    input  wire logic [PW-1:0]  in_pl,
    output logic                out_valid,
    output logic [QW-1:0]       out_quo,
    output logic [PW-1:0]       out_pl
);

    logic [QW-1:0] vld_reg;
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [PW-1:0] pl_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_src;
        logic [QW-1:0] lo_src;
        logic [QW-1:0] quo_src;
        logic [DW-1:0] den_src;
        logic [PW-1:0] pl_src;
        logic          vld_src;
        logic [DW:0]   rem_sh;
        logic          ge;
        logic [DW:0]   rem_diff;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] lo_next;
        logic [QW-1:0] quo_next;

        // stage source: module inputs or previous stage
        if (k == 0) begin : g_first
            assign rem_src = DW'(in_num[NW-1:QW]);
            assign lo_src  = in_num[QW-1:0];
            assign quo_src = '0;
            assign den_src = in_den;
            assign pl_src  = in_pl;
            assign vld_src = in_valid;
        end else begin : g_next
            assign rem_src = rem_reg[k-1];
            assign lo_src  = lo_reg[k-1];
            assign quo_src = quo_reg[k-1];
            assign den_src = den_reg[k-1];
            assign pl_src  = pl_reg[k-1];
            assign vld_src = vld_reg[k-1];
        end

        // shift in one numerator bit, compare and subtract
        always_comb
        begin
            rem_sh   = {rem_src, lo_src[QW-1]};
            ge       = (rem_sh >= {1'b0, den_src});
            rem_diff = ge ? (rem_sh - {1'b0, den_src}) : rem_sh;
            rem_next = rem_diff[DW-1:0];
            lo_next  = {lo_src[QW-2:0], 1'b0};
            quo_next = {quo_src[QW-2:0], ge};
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_src;
            end
        end

        // stage data
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                lo_reg[k]  <= lo_next;
                quo_reg[k] <= quo_next;
                den_reg[k] <= den_src;
                pl_reg[k]  <= pl_src;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_pl    = pl_reg[QW-1];

endmodule

`default_nettype wire

### hw/rtl/asf_apb_regs.sv
// asf_apb_regs: configuration registers behind an apb-style port
// depends on asf_pkg for the register codes and the configuration struct
`default_nettype none

module asf_apb_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [asf_pkg::ASF_ADDR_W-1:0] paddr,
    input  wire logic [asf_pkg::ASF_DATA_W-1:0] pwdata,
    output logic      [asf_pkg::ASF_DATA_W-1:0] prdata,
    output logic                                pready,
    output asf_pkg::asf_cfg_t                   cfg
);

    import asf_pkg::*;

    asf_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    // register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_speed  <= ASF_MAX_SPEED_RST;
            cfg_reg.max_force  <= ASF_MAX_FORCE_RST;
            cfg_reg.gain       <= ASF_WEIGHT_RST;
            cfg_reg.decel_rate <= ASF_DECEL_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ASF_REG_MAX_SPEED: cfg_reg.max_speed  <= pwdata[30:0];
                ASF_REG_MAX_FORCE: cfg_reg.max_force  <= pwdata[30:0];
                ASF_REG_WEIGHT:    cfg_reg.gain       <= pwdata[15:0];
                ASF_REG_DECEL:     cfg_reg.decel_rate <= pwdata[1:0];
                default:           cfg_reg.decel_rate <= cfg_reg.decel_rate;
            endcase
        end
    end

    // read data mux
    always_comb
    begin
        unique case (idx)
            ASF_REG_MAX_SPEED: prdata = {1'b0, cfg_reg.max_speed};
            ASF_REG_MAX_FORCE: prdata = {1'b0, cfg_reg.max_force};
            ASF_REG_WEIGHT:    prdata = {16'd0, cfg_reg.gain};
            ASF_REG_DECEL:     prdata = {30'd0, cfg_reg.decel_rate};
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hw/rtl/arrive_steering_force_core.sv
// arrive_steering_force_core: pipelined arrive steering force, input transfer to m_tvalid
// throughput one item per cycle; all stages advance together and hold while
// the output register is full and m_tready is low
// the pipeline length is dominated by the bit-per-stage roots (33 and 57) and dividers (33, 63, 31)
// rst_n clears all valid bits and loads the register reset values; no clearing pass
// depends on asf_pkg, asf_apb_regs, asf_sqrt_pipe and asf_div_pipe
`default_nettype none

module arrive_steering_force_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // slave stream, tdata: position_x, position_y, position_z, velocity_x,
    // velocity_y, velocity_z, target_x, target_y, target_z (32 bits each)
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [287:0]                   s_tdata,
    // master stream, tdata: force_x, force_y, force_z (32 bits each)
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [95:0]                    m_tdata,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [asf_pkg::ASF_ADDR_W-1:0] paddr,
    input  wire logic [asf_pkg::ASF_DATA_W-1:0] pwdata,
    output logic      [asf_pkg::ASF_DATA_W-1:0] prdata,
    output logic                                pready
);

    import asf_pkg::*;

    asf_cfg_t cfg;
    logic     adv;

    asf_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // global advance: the whole pipe moves unless the output is blocked
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- offset ----------------
    logic             dlt_vld_reg;
    logic [2:0][32:0] dlt_next, dlt_reg;
    logic [2:0][31:0] vel0_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dlt_next[i] = {s_tdata[192+32*i+31], s_tdata[192+32*i +: 32]}
                        - {s_tdata[32*i+31], s_tdata[32*i +: 32]};
        end
    end

    // ---------------- magnitude ----------------
    logic             mag_vld_reg;
    logic [2:0][32:0] dmag_next, dmag_reg;
    logic [2:0]       dneg_next, dneg_reg;
    logic [2:0][31:0] vel1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dneg_next[i] = dlt_reg[i][32];
            dmag_next[i] = dlt_reg[i][32] ? (33'd0 - dlt_reg[i]) : dlt_reg[i];
        end
    end

    // ---------------- squares ----------------
    logic             sq_vld_reg;
    logic [2:0][65:0] dsq_next, dsq_reg;
    asf_vec_t         vec_sq_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dsq_next[i] = 66'(dmag_reg[i]) * 66'(dmag_reg[i]);
        end
    end

    // ---------------- sum ----------------
    logic        sum_vld_reg;
    logic [65:0] dsum_next, dsum_reg;
    asf_vec_t    vec_sum_reg;

    assign dsum_next = dsq_reg[0] + dsq_reg[1] + dsq_reg[2];

    // front stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlt_vld_reg <= 1'b0;
            mag_vld_reg <= 1'b0;
            sq_vld_reg  <= 1'b0;
            sum_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            dlt_vld_reg <= s_tvalid;
            mag_vld_reg <= dlt_vld_reg;
            sq_vld_reg  <= mag_vld_reg;
            sum_vld_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dlt_reg            <= dlt_next;
            vel0_reg           <= s_tdata[191:96];
            dmag_reg           <= dmag_next;
            dneg_reg           <= dneg_next;
            vel1_reg           <= vel0_reg;
            dsq_reg            <= dsq_next;
            vec_sq_reg.dmag    <= dmag_reg;
            vec_sq_reg.dneg    <= dneg_reg;
            vec_sq_reg.vel     <= vel1_reg;
            dsum_reg           <= dsum_next;
            vec_sum_reg        <= vec_sq_reg;
        end
    end

    // ---------------- distance root ----------------
    logic        rt1_vld;
    logic [32:0] dlen;
    asf_vec_t    vec_rt1;

    asf_sqrt_pipe #(
        .XW (66),
        .PW ($bits(asf_vec_t))
    ) u_sqrt_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sum_vld_reg),
        .in_x      (dsum_reg),
        .in_pl     (vec_sum_reg),
        .out_valid (rt1_vld),
        .out_root  (dlen),
        .out_pl    (vec_rt1)
    );

    // ---------------- speed divider ----------------
    logic [3:0]  decel_div;
    asf_spd_pl_t spd_in, spd_out;
    logic        dv3_vld;
    logic [32:0] dv3_quo;

    always_comb
    begin
        unique case (cfg.decel_rate)
            ASF_DECEL_FAST:   decel_div = 4'd3;
            ASF_DECEL_NORMAL: decel_div = 4'd6;
            ASF_DECEL_SLOW:   decel_div = 4'd9;
            default:          decel_div = 4'd3;
        endcase
    end

    assign spd_in.vec  = vec_rt1;
    assign spd_in.dlen = dlen;

    asf_div_pipe #(
        .NW (34),
        .DW (4),
        .QW (33),
        .PW ($bits(asf_spd_pl_t))
    ) u_div_speed (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (rt1_vld),
        .in_num    ({1'b0, dlen}),
        .in_den    (decel_div),
        .in_pl     (spd_in),
        .out_valid (dv3_vld),
        .out_quo   (dv3_quo),
        .out_pl    (spd_out)
    );

    // ---------------- speed cap and scaled offset ----------------
    logic             spd_vld_reg, prd_vld_reg;
    logic [30:0]      speed_next, speed_reg;
    asf_spd_pl_t      spd_pl_reg;
    logic [2:0][63:0] prd_next, prd_reg;
    logic [2:0]       prd_dneg_reg;
    logic [2:0][31:0] prd_vel_reg;
    logic [32:0]      prd_dist_reg;
    logic             prd_dnz_reg;

    always_comb
    begin
        if (cfg.decel_rate == ASF_DECEL_NONE || dv3_quo > {2'b00, cfg.max_speed})
        begin
            speed_next = cfg.max_speed;
        end
        else
        begin
            speed_next = dv3_quo[30:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prd_next[i] = 64'(spd_pl_reg.vec.dmag[i]) * 64'(speed_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_vld_reg <= 1'b0;
            prd_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            spd_vld_reg <= dv3_vld;
            prd_vld_reg <= spd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            speed_reg    <= speed_next;
            spd_pl_reg   <= spd_out;
            prd_reg      <= prd_next;
            prd_dneg_reg <= spd_pl_reg.vec.dneg;
            prd_vel_reg  <= spd_pl_reg.vec.vel;
            prd_dist_reg <= spd_pl_reg.dlen;
            prd_dnz_reg  <= (spd_pl_reg.dlen != '0);
        end
    end

    // ---------------- desired velocity dividers ----------------
    logic [2:0]       dv1_vld;
    logic [2:0][62:0] dv1_quo;
    asf_des_pl_t      des_in  [3];
    asf_des_pl_t      des_out [3];

    for (genvar i = 0; i < 3; i++) begin : g_des
        assign des_in[i].dnz  = prd_dnz_reg;
        assign des_in[i].dneg = prd_dneg_reg[i];
        assign des_in[i].vel  = prd_vel_reg[i];

        asf_div_pipe #(
            .NW (64),
            .DW (33),
            .QW (63),
            .PW ($bits(asf_des_pl_t))
        ) u_div_desired (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (prd_vld_reg),
            .in_num    (prd_reg[i]),
            .in_den    (prd_dist_reg),
            .in_pl     (des_in[i]),
            .out_valid (dv1_vld[i]),
            .out_quo   (dv1_quo[i]),
            .out_pl    (des_out[i])
        );
    end

    // ---------------- steering difference, weight, squares ----------------
    logic               acc_vld_reg, amg_vld_reg, wgt_vld_reg, pp_vld_reg;
    logic               wsq_vld_reg, wsum_vld_reg;
    logic [2:0][63:0]   acc_next, acc_reg;
    logic [2:0][63:0]   amag_next, amag_reg;
    logic [2:0]         aneg_reg;
    logic [2:0][63:0]   wprod;
    logic [2:0][55:0]   wmag_next, wmag_reg;
    logic [2:0]         wneg_reg;
    logic [2:0][55:0]   hh_next, hh_reg, hl_next, hl_reg, ll_next, ll_reg;
    asf_w_pl_t          w_pp_reg, w_sq_reg, w_sum_reg;
    logic [2:0][111:0]  wsq_next, wsq_reg;
    logic [113:0]       wsum_next, wsum_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (des_out[i].dnz)
            begin
                acc_next[i] = (des_out[i].dneg ? (64'd0 - {1'b0, dv1_quo[i]})
                                               : {1'b0, dv1_quo[i]})
                            - {{32{des_out[i].vel[31]}}, des_out[i].vel};
            end
            else
            begin
                acc_next[i] = '0;
            end
            amag_next[i] = acc_reg[i][63] ? (64'd0 - acc_reg[i]) : acc_reg[i];
            wprod[i]     = amag_reg[i] * {48'd0, cfg.gain};
            wmag_next[i] = wprod[i][63:8];
            hh_next[i]   = wmag_reg[i][55:28] * wmag_reg[i][55:28];
            hl_next[i]   = wmag_reg[i][55:28] * wmag_reg[i][27:0];
            ll_next[i]   = wmag_reg[i][27:0] * wmag_reg[i][27:0];
            wsq_next[i]  = (112'(hh_reg[i]) << 56) + (112'(hl_reg[i]) << 29)
                         + 112'(ll_reg[i]);
        end
    end

    assign wsum_next = 114'(wsq_reg[0]) + 114'(wsq_reg[1]) + 114'(wsq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg  <= 1'b0;
            amg_vld_reg  <= 1'b0;
            wgt_vld_reg  <= 1'b0;
            pp_vld_reg   <= 1'b0;
            wsq_vld_reg  <= 1'b0;
            wsum_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            acc_vld_reg  <= &dv1_vld;
            amg_vld_reg  <= acc_vld_reg;
            wgt_vld_reg  <= amg_vld_reg;
            pp_vld_reg   <= wgt_vld_reg;
            wsq_vld_reg  <= pp_vld_reg;
            wsum_vld_reg <= wsq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg       <= acc_next;
            amag_reg      <= amag_next;
            for (int i = 0; i < 3; i++)
            begin
                aneg_reg[i] <= acc_reg[i][63];
            end
            wmag_reg      <= wmag_next;
            wneg_reg      <= aneg_reg;
            hh_reg        <= hh_next;
            hl_reg        <= hl_next;
            ll_reg        <= ll_next;
            w_pp_reg.wmag <= wmag_reg;
            w_pp_reg.wneg <= wneg_reg;
            wsq_reg       <= wsq_next;
            w_sq_reg      <= w_pp_reg;
            wsum_reg      <= wsum_next;
            w_sum_reg     <= w_sq_reg;
        end
    end

    // ---------------- force length root ----------------
    logic        rt2_vld;
    logic [56:0] flen;
    asf_w_pl_t   w_rt2;

    asf_sqrt_pipe #(
        .XW (114),
        .PW ($bits(asf_w_pl_t))
    ) u_sqrt_force (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (wsum_vld_reg),
        .in_x      (wsum_reg),
        .in_pl     (w_sum_reg),
        .out_valid (rt2_vld),
        .out_root  (flen),
        .out_pl    (w_rt2)
    );

    // ---------------- clip products ----------------
    logic             cph_vld_reg, cpn_vld_reg;
    logic [2:0][58:0] ph_next, ph_reg, pl_next, pl_reg;
    logic [56:0]      flen_reg, flen2_reg;
    logic             zero_next, zero_reg;
    logic             le_next, le_reg;
    logic [2:0]       cwneg_reg;
    logic [2:0][30:0] cwlow_reg;
    logic [2:0][86:0] cnum_next, cnum_reg;
    asf_f_pl_t        f_in [3];

    assign zero_next = (cfg.max_force == '0) || (flen == '0);
    assign le_next   = (flen <= {26'd0, cfg.max_force});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ph_next[i]   = w_rt2.wmag[i][55:28] * cfg.max_force;
            pl_next[i]   = w_rt2.wmag[i][27:0] * cfg.max_force;
            cnum_next[i] = (87'(ph_reg[i]) << 28) + 87'(pl_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cph_vld_reg <= 1'b0;
            cpn_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            cph_vld_reg <= rt2_vld;
            cpn_vld_reg <= cph_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ph_reg    <= ph_next;
            pl_reg    <= pl_next;
            flen_reg  <= flen;
            zero_reg  <= zero_next;
            le_reg    <= le_next;
            for (int i = 0; i < 3; i++)
            begin
                cwlow_reg[i] <= w_rt2.wmag[i][30:0];
            end
            cwneg_reg <= w_rt2.wneg;
            cnum_reg  <= cnum_next;
            flen2_reg <= flen_reg;
            for (int i = 0; i < 3; i++)
            begin
                f_in[i].zero <= zero_reg;
                f_in[i].le   <= le_reg;
                f_in[i].wneg <= cwneg_reg[i];
                f_in[i].wlow <= cwlow_reg[i];
            end
        end
    end

    // ---------------- clip dividers ----------------
    logic [2:0]       dv2_vld;
    logic [2:0][30:0] dv2_quo;
    asf_f_pl_t        f_out [3];

    for (genvar i = 0; i < 3; i++) begin : g_clip
        asf_div_pipe #(
            .NW (87),
            .DW (57),
            .QW (31),
            .PW ($bits(asf_f_pl_t))
        ) u_div_clip (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (cpn_vld_reg),
            .in_num    (cnum_reg[i]),
            .in_den    (flen2_reg),
            .in_pl     (f_in[i]),
            .out_valid (dv2_vld[i]),
            .out_quo   (dv2_quo[i]),
            .out_pl    (f_out[i])
        );
    end

    // ---------------- output register ----------------
    logic             out_vld_reg;
    logic             out_zero_reg;
    logic [2:0][31:0] frc_next, frc_reg;
    logic [2:0][30:0] fm;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (f_out[i].zero)
            begin
                fm[i] = '0;
            end
            else if (f_out[i].le)
            begin
                fm[i] = f_out[i].wlow;
            end
            else
            begin
                fm[i] = dv2_quo[i];
            end
            frc_next[i] = f_out[i].wneg ? (32'd0 - {1'b0, fm[i]}) : {1'b0, fm[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= &dv2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            frc_reg      <= frc_next;
            out_zero_reg <= f_out[0].zero;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = frc_reg;

`ifndef SYNTH
    // an accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> dlt_vld_reg)
        else $error("accepted item missing from first stage");

    // the three desired velocity lanes stay in lock step
    a_des_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (dv1_vld[0] == dv1_vld[1]) && (dv1_vld[1] == dv1_vld[2]))
        else $error("desired velocity lanes out of step");

    // the three clip lanes stay in lock step
    a_clip_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (dv2_vld[0] == dv2_vld[1]) && (dv2_vld[1] == dv2_vld[2]))
        else $error("clip lanes out of step");

    // a zero force cap or zero length gives a zero result
    a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_zero_reg) |-> (m_tdata == '0))
        else $error("nonzero force where zero is due");
`endif

endmodule

`default_nettype wire
